[rtl/pidaw_pkg.sv]
// Shared types, widths and constants for the PID controller with anti-windup.
// No dependencies; compiled first.
package pidaw_pkg;

  localparam int unsigned DATA_W    = 32;  // Q16.16 data words
  localparam int unsigned DT_W      = 31;  // unsigned time step
  localparam int unsigned FRAC_W    = 16;  // fractional bits
  localparam int unsigned ERR_W     = DATA_W + 1;
  localparam int unsigned PROD_W    = 2 * ERR_W;
  localparam int unsigned TERM_W    = 49;  // P, I, D terms after rescale
  localparam int unsigned SUM_W     = 51;
  localparam int unsigned MAG_W     = 63;  // |gain_deriv * delta|
  localparam int unsigned QUO_W     = 48;  // quotient bits kept by the divider
  localparam int unsigned DIV_STEPS = QUO_W / 2;  // two bits per cycle
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [QUO_W-1:0] D_LIMIT = QUO_W'(1) << (QUO_W - 1);

  localparam logic signed [DATA_W-1:0] DRIVE_FLOOR_RST   = -32'sd65536;
  localparam logic signed [DATA_W-1:0] DRIVE_CEILING_RST = 32'sd65536;
  localparam logic [DT_W-1:0]          WINDUP_BOUND_RST  = 31'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP     = 3'd0,
    CFG_GAIN_INTEG    = 3'd1,
    CFG_GAIN_DERIV    = 3'd2,
    CFG_DRIVE_FLOOR   = 3'd3,
    CFG_DRIVE_CEILING = 3'd4,
    CFG_WINDUP_BOUND  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_prop;
    logic signed [DATA_W-1:0] gain_integ;
    logic signed [DATA_W-1:0] gain_deriv;
    logic signed [DATA_W-1:0] drive_floor;
    logic signed [DATA_W-1:0] drive_ceiling;
    logic [DT_W-1:0]          windup_bound;
  } cfg_regs_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_DIFF,
    OP_MUL_P,
    OP_MUL_E,
    OP_ACC_ADD,
    OP_ACC_CLAMP,
    OP_MUL_I,
    OP_MUL_D,
    OP_ABS,
    OP_DIV_CHK,
    OP_DIV_STEP,
    OP_DVAL,
    OP_SUM,
    OP_EMIT,
    OP_RESTART
  } dp_op_t;

  typedef struct packed {
    logic   load;  // capture the input transaction
    dp_op_t op;
  } dp_cmd_t;

endpackage

[rtl/pidaw_in_if.sv]
// Input channel interface: valid/ready handshake with the step payload.
// Depends on pidaw_pkg.
interface pidaw_in_if import pidaw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] sensed;
  logic [DT_W-1:0]          step_time;
  logic                     restart;

  modport source (output valid, target, sensed, step_time, restart, input ready);
  modport sink   (input valid, target, sensed, step_time, restart, output ready);
endinterface

[rtl/pidaw_out_if.sv]
// Result channel interface: valid/ready handshake with the drive value.
// Depends on pidaw_pkg.
interface pidaw_out_if import pidaw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

[rtl/pidaw_cfg.sv]
// Configuration register file: gains, drive limits and windup bound.
// Depends on pidaw_pkg.
module pidaw_cfg import pidaw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  output cfg_regs_t            cfg
);

  cfg_regs_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop     <= '0;
      cfg_r.gain_integ    <= '0;
      cfg_r.gain_deriv    <= '0;
      cfg_r.drive_floor   <= DRIVE_FLOOR_RST;
      cfg_r.drive_ceiling <= DRIVE_CEILING_RST;
      cfg_r.windup_bound  <= WINDUP_BOUND_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN_PROP:     cfg_r.gain_prop     <= cfg_wdata;
        CFG_GAIN_INTEG:    cfg_r.gain_integ    <= cfg_wdata;
        CFG_GAIN_DERIV:    cfg_r.gain_deriv    <= cfg_wdata;
        CFG_DRIVE_FLOOR:   cfg_r.drive_floor   <= cfg_wdata;
        CFG_DRIVE_CEILING: cfg_r.drive_ceiling <= cfg_wdata;
        CFG_WINDUP_BOUND:  cfg_r.windup_bound  <= cfg_wdata[DT_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/pidaw_datapath.sv]
// PID datapath: shared 33x33 multiplier, integral clamp, 2-bit/cycle divider,
// output clamp and result register. Driven by pidaw_ctrl; depends on pidaw_pkg.
module pidaw_datapath import pidaw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  input  cfg_regs_t                cfg,
  input  logic signed [DATA_W-1:0] in_target,
  input  logic signed [DATA_W-1:0] in_sensed,
  input  logic [DT_W-1:0]          in_step_time,
  output logic signed [DATA_W-1:0] drive
);

  // state kept across transactions
  logic signed [DATA_W-1:0] accum_r;
  logic signed [DATA_W-1:0] last_r;

  // per-transaction working registers
  logic signed [DATA_W-1:0] tgt_r, meas_r;
  logic [DT_W-1:0]          dt_r;
  logic signed [ERR_W-1:0]  err_r, delta_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [TERM_W-1:0] p_r, i_r, d_r;
  logic signed [SUM_W-1:0]  acc_sum_r, sum_r;
  logic [MAG_W-1:0]         mag_r;
  logic [DT_W-1:0]          rem_r;
  logic [QUO_W-1:0]         q_r;
  logic                     neg_r, sat_r;
  logic signed [DATA_W-1:0] drive_r;

  // shared multiplier
  logic signed [ERR_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_y;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_P: begin
        mul_a = {cfg.gain_prop[DATA_W-1], cfg.gain_prop};
        mul_b = err_r;
      end
      OP_MUL_E: begin
        mul_a = err_r;
        mul_b = {2'b00, dt_r};
      end
      OP_MUL_I: begin
        mul_a = {cfg.gain_integ[DATA_W-1], cfg.gain_integ};
        mul_b = {accum_r[DATA_W-1], accum_r};
      end
      OP_MUL_D: begin
        mul_a = {cfg.gain_deriv[DATA_W-1], cfg.gain_deriv};
        mul_b = delta_r;
      end
      default: ;
    endcase
  end

  assign mul_y = PROD_W'(mul_a) * PROD_W'(mul_b);

  // product rescaled by floor(x / 2^16)
  logic signed [TERM_W-1:0] prod_q;
  assign prod_q = prod_r[FRAC_W+TERM_W-1:FRAC_W];

  logic [PROD_W-1:0] prod_neg;
  assign prod_neg = -prod_r;

  // integral clamp bounds
  logic signed [SUM_W-1:0] wb_pos, wb_neg;
  assign wb_pos = {{(SUM_W-DT_W){1'b0}}, cfg.windup_bound};
  assign wb_neg = -wb_pos;

  // divider: two restoring steps per cycle
  logic [DT_W:0]   dv, r1, r1s, r2, r2s;
  logic            ge1, ge2;
  assign dv  = {1'b0, dt_r};
  assign r1  = {rem_r, mag_r[QUO_W-1]};
  assign ge1 = r1 >= dv;
  assign r1s = ge1 ? r1 - dv : r1;
  assign r2  = {r1s[DT_W-1:0], mag_r[QUO_W-2]};
  assign ge2 = r2 >= dv;
  assign r2s = ge2 ? r2 - dv : r2;

  // D term magnitude with saturation
  logic [QUO_W-1:0] q_sat;
  assign q_sat = (sat_r || (q_r > D_LIMIT)) ? D_LIMIT : q_r;

  // output clamp
  logic signed [SUM_W-1:0] floor_x, ceil_x;
  assign floor_x = {{(SUM_W-DATA_W){cfg.drive_floor[DATA_W-1]}}, cfg.drive_floor};
  assign ceil_x  = {{(SUM_W-DATA_W){cfg.drive_ceiling[DATA_W-1]}}, cfg.drive_ceiling};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      last_r  <= '0;
    end else begin
      case (cmd.op)
        OP_DIFF:    last_r <= meas_r;
        OP_ACC_CLAMP: begin
          if (acc_sum_r < wb_neg)      accum_r <= wb_neg[DATA_W-1:0];
          else if (acc_sum_r > wb_pos) accum_r <= wb_pos[DATA_W-1:0];
          else                         accum_r <= acc_sum_r[DATA_W-1:0];
        end
        OP_RESTART: begin
          accum_r <= '0;
          last_r  <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_r  <= in_target;
      meas_r <= in_sensed;
      dt_r   <= in_step_time;
    end
    case (cmd.op)
      OP_DIFF: begin
        err_r   <= {tgt_r[DATA_W-1], tgt_r} - {meas_r[DATA_W-1], meas_r};
        delta_r <= {meas_r[DATA_W-1], meas_r} - {last_r[DATA_W-1], last_r};
      end
      OP_MUL_P: prod_r <= mul_y;
      OP_MUL_E: begin
        p_r    <= prod_q;
        prod_r <= mul_y;
      end
      OP_ACC_ADD: acc_sum_r <= {{(SUM_W-DATA_W){accum_r[DATA_W-1]}}, accum_r}
                             + {{(SUM_W-TERM_W){prod_q[TERM_W-1]}}, prod_q};
      OP_MUL_I: prod_r <= mul_y;
      OP_MUL_D: begin
        i_r    <= prod_q;
        prod_r <= mul_y;
      end
      OP_ABS: begin
        neg_r <= prod_r[PROD_W-1];
        mag_r <= prod_r[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod_r[MAG_W-1:0];
      end
      OP_DIV_CHK: begin
        // quotient of 2^48 or more saturates anyway
        sat_r <= {{(DT_W-(MAG_W-QUO_W)){1'b0}}, mag_r[MAG_W-1:QUO_W]} >= dt_r;
        rem_r <= {{(DT_W-(MAG_W-QUO_W)){1'b0}}, mag_r[MAG_W-1:QUO_W]};
        q_r   <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= r2s[DT_W-1:0];
        q_r   <= {q_r[QUO_W-3:0], ge1, ge2};
        mag_r <= {mag_r[MAG_W-3:0], 2'b00};
      end
      OP_DVAL: begin
        if (dt_r == '0)  d_r <= '0;
        else if (neg_r)  d_r <= {1'b0, q_sat};
        else             d_r <= -{1'b0, q_sat};
      end
      OP_SUM: sum_r <= {{(SUM_W-TERM_W){p_r[TERM_W-1]}}, p_r}
                     + {{(SUM_W-TERM_W){i_r[TERM_W-1]}}, i_r}
                     + {{(SUM_W-TERM_W){d_r[TERM_W-1]}}, d_r};
      OP_EMIT: begin
        if (sum_r < floor_x)      drive_r <= cfg.drive_floor;
        else if (sum_r > ceil_x)  drive_r <= cfg.drive_ceiling;
        else                      drive_r <= sum_r[DATA_W-1:0];
      end
      OP_RESTART: drive_r <= '0;
      default: ;
    endcase
  end

  assign drive = drive_r;

endmodule

[rtl/pidaw_ctrl.sv]
// Sequencer for the PID datapath: steps one transaction through the shared
// multiplier and divider and owns the result valid flag. Depends on pidaw_pkg.
module pidaw_ctrl import pidaw_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_restart,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  typedef enum logic [14:0] {
    ST_IDLE      = 15'b000000000000001,
    ST_DIFF      = 15'b000000000000010,
    ST_MUL_P     = 15'b000000000000100,
    ST_MUL_E     = 15'b000000000001000,
    ST_ACC_ADD   = 15'b000000000010000,
    ST_ACC_CLAMP = 15'b000000000100000,
    ST_MUL_I     = 15'b000000001000000,
    ST_MUL_D     = 15'b000000010000000,
    ST_ABS       = 15'b000000100000000,
    ST_DIV_CHK   = 15'b000001000000000,
    ST_DIV_RUN   = 15'b000010000000000,
    ST_DVAL      = 15'b000100000000000,
    ST_SUM       = 15'b001000000000000,
    ST_EMIT      = 15'b010000000000000,
    ST_RESTART   = 15'b100000000000000
  } ctrl_state_t;

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.load      = 1'b0;
    cmd.op        = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_restart ? ST_RESTART : ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.op    = OP_MUL_P;
        state_nxt = ST_MUL_E;
      end
      ST_MUL_E: begin
        cmd.op    = OP_MUL_E;
        state_nxt = ST_ACC_ADD;
      end
      ST_ACC_ADD: begin
        cmd.op    = OP_ACC_ADD;
        state_nxt = ST_ACC_CLAMP;
      end
      ST_ACC_CLAMP: begin
        cmd.op    = OP_ACC_CLAMP;
        state_nxt = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.op    = OP_MUL_I;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.op    = OP_MUL_D;
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        cmd.op    = OP_ABS;
        state_nxt = ST_DIV_CHK;
      end
      ST_DIV_CHK: begin
        cmd.op    = OP_DIV_CHK;
        cnt_nxt   = '0;
        state_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DVAL;
        end
      end
      ST_DVAL: begin
        cmd.op    = OP_DVAL;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RESTART: begin
        if (out_free) begin
          cmd.op        = OP_RESTART;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/pid_controller_antiwindup.sv]
// PID controller, derivative on measurement, with integral anti-windup.
// Top level: config registers, sequencer and datapath. Depends on pidaw_pkg,
// pidaw_in_if, pidaw_out_if, pidaw_cfg, pidaw_ctrl and pidaw_datapath.
//
// Usage:
//   in_ch  : one transaction per control step (target, sensed, step_time,
//            restart), target and sensed signed Q16.16, step_time unsigned.
//   out_ch : exactly one drive transaction per input transaction, in order.
//   cfg_*  : write-only register port, index = gain_prop, gain_integ,
//            gain_deriv, drive_floor, drive_ceiling, windup_bound (0..5);
//            higher indexes are ignored. Write only while the block is idle.
// Sequence: a normal step is taken in the idle state and then runs through
//   the sequencer states in order, the 48-bit D quotient coming two bits per
//   cycle from the restoring divider, plus four passes through the one shared
//   33x33 multiplier; the next step is taken only back in the idle state, once
//   the drive is written. A restart goes to the restart state, which writes 0.
// Reset: synchronous, active low; gains to zero, limits to +/-1.0, the
//   integral and the previous measurement to zero.
// Stall: the drive sits in an output register; a new transaction is taken
//   while it waits, and the sequencer holds before writing the next result.
module pid_controller_antiwindup import pidaw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pidaw_in_if.sink             in_ch,
  pidaw_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  cfg_regs_t cfg;
  dp_cmd_t   cmd;

  // register file
  pidaw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer: handshakes and one datapath command per cycle
  pidaw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd)
  );

  // arithmetic, controller state and the result register
  pidaw_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg          (cfg),
    .in_target    (in_ch.target),
    .in_sensed    (in_ch.sensed),
    .in_step_time (in_ch.step_time),
    .drive        (out_ch.drive)
  );

`ifndef NO_ASSERTIONS
  // one transaction in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a transaction is in flight");

  // a result never appears the cycle right after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !$rose(out_ch.valid))
    else $error("result raised too early after accept");

  // a new result only follows a command that wrote the output register
  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> ($past(cmd.op) == OP_EMIT || $past(cmd.op) == OP_RESTART))
    else $error("result valid without an output write");
`endif

endmodule
